### rtl/k_way_sorted_merge_defines.svh
// Assertion macros shared by the merge block.
`ifndef K_WAY_SORTED_MERGE_DEFINES_SVH
`define K_WAY_SORTED_MERGE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define KWM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define KWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Types, sizes and codes shared by the sorted-list merge block.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int LISTS   = 8;
    localparam int DEPTH   = 64;
    localparam int LIST_W  = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int DEPTH_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int NODES   = 2 ** LIST_W;
    localparam int ADDR_W  = LIST_W + DEPTH_W;
    localparam int MEM_WORDS = 2 ** ADDR_W;

    // Operation codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_POP   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_ORDER = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         list_index;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [2:0]         source_list;
        logic [1:0]         status;
    } out_item_t;

    // Result of the head selection
    typedef struct packed {
        logic               found;
        logic [LIST_W-1:0]  idx;
        logic signed [31:0] value;
    } winner_t;

endpackage

### rtl/kwm_min_sel.sv
// ----------------------------------------------------------------------------
// kwm_min_sel
// Selects the smallest valid head over all lists with a balanced compare
// tree; on equal values the list with the higher index wins.
// ----------------------------------------------------------------------------
module kwm_min_sel (
    input  logic signed [31:0]       head_value [kwm_pkg::LISTS],
    input  logic [kwm_pkg::LISTS-1:0] head_valid,
    output kwm_pkg::winner_t         winner
);
    import kwm_pkg::*;

    winner_t node [2*NODES];

    // Pick the right-hand (higher index) side when it is not larger
    function automatic winner_t pick(input winner_t lo, input winner_t hi);
        winner_t r;
        if (hi.found && (!lo.found || hi.value <= lo.value)) begin
            r = hi;
        end else begin
            r = lo;
        end
        return r;
    endfunction

    // Build leaves, then reduce pairs level by level
    always_comb begin
        node[0] = '0;
        for (int i = 0; i < NODES; i++) begin
            if (i < LISTS) begin
                node[NODES+i].found = head_valid[i];
                node[NODES+i].idx   = LIST_W'(i);
                node[NODES+i].value = head_value[i];
            end else begin
                node[NODES+i] = '0;
            end
        end
        for (int i = NODES - 1; i >= 1; i--) begin
            node[i] = pick(node[2*i], node[2*i+1]);
        end
    end

    assign winner = node[1];

endmodule

### rtl/k_way_sorted_merge.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge: result appears in the cycle after the input transaction.
// A pop that advances into a stored entry holds off the next transaction
// (refill of the head from element memory); others wait only on output stalls.
// Reset clears counts and head flags; the element memory is not cleared and
// needs no clearing pass.
// ----------------------------------------------------------------------------
`include "k_way_sorted_merge_defines.svh"

module k_way_sorted_merge (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  kwm_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output kwm_pkg::out_item_t m_data
);
    import kwm_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_REFILL = 1'b1;

    // Element memory, one region of DEPTH words per list
    logic signed [31:0] mem [MEM_WORDS];
    logic signed [31:0] rd_data_reg;

    // Per-list state
    logic [CNT_W-1:0]   rp_reg          [LISTS];
    logic [CNT_W-1:0]   wc_reg          [LISTS];
    logic signed [31:0] last_loaded_reg [LISTS];
    logic signed [31:0] head_value_reg  [LISTS];
    logic [LISTS-1:0]   head_valid_reg;

    logic              state_reg, state_next;
    logic [LIST_W-1:0] refill_list_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    in_item_t          req;
    winner_t           win;
    logic              accept, idx_ok, full, order, more;
    logic [LIST_W-1:0] lsel, sel;
    logic [CNT_W-1:0]  wc_sel, rp_sel, rp_inc;
    logic signed [31:0] last_sel;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              do_write, do_pop, do_read, do_clear;
    out_item_t         res;

    assign req    = s_data;
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    kwm_min_sel u_min_sel (
        .head_value (head_value_reg),
        .head_valid (head_valid_reg),
        .winner     (win)
    );

    // Decode the transaction against the selected list
    always_comb begin
        idx_ok   = int'(req.list_index) < LISTS;
        lsel     = LIST_W'(req.list_index);
        sel      = (req.func == FUNC_POP) ? win.idx : lsel;
        wc_sel   = wc_reg[sel];
        rp_sel   = rp_reg[sel];
        last_sel = last_loaded_reg[sel];
        rp_inc   = rp_sel + CNT_W'(1);
        more     = rp_inc < wc_sel;
        full     = !idx_ok || (wc_sel >= CNT_W'(DEPTH));
        order    = (wc_sel != '0) && (req.value < last_sel);
        wr_addr  = {lsel, wc_sel[DEPTH_W-1:0]};
        rd_addr  = {win.idx, rp_inc[DEPTH_W-1:0]};
        do_write = accept && (req.func == FUNC_LOAD) && !full && !order;
        do_pop   = accept && (req.func == FUNC_POP) && win.found;
        do_read  = do_pop && more;
        do_clear = accept && (req.func == FUNC_CLEAR);
    end

    // Form the result
    always_comb begin
        res = '0;
        unique case (req.func)
            FUNC_LOAD: begin
                if (full) begin
                    res.status = STAT_FULL;
                end else if (order) begin
                    res.status = STAT_ORDER;
                end
            end
            FUNC_POP: begin
                if (!win.found) begin
                    res.status = STAT_EMPTY;
                end else begin
                    res.out_value   = win.value;
                    res.source_list = 3'(win.idx);
                end
            end
            FUNC_CLEAR: res.status = STAT_OK;
            FUNC_NOP:   res.status = STAT_OK;
            default:    res.status = STAT_OK;
        endcase
    end

    // Next state: a pop that advances into stored entries refills a head
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (do_read) state_next = ST_REFILL;
            ST_REFILL: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Memory write on load, read of the next entry on pop
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[wr_addr] <= req.value;
        end
        if (do_read) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            head_valid_reg <= '0;
            for (int i = 0; i < LISTS; i++) begin
                rp_reg[i] <= '0;
                wc_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (do_clear) begin
                head_valid_reg <= '0;
                for (int i = 0; i < LISTS; i++) begin
                    rp_reg[i] <= '0;
                    wc_reg[i] <= '0;
                end
            end
            if (do_write) begin
                wc_reg[lsel] <= wc_sel + CNT_W'(1);
                head_valid_reg[lsel] <= 1'b1;
            end
            if (do_pop) begin
                rp_reg[win.idx] <= rp_inc;
                if (!more) begin
                    head_valid_reg[win.idx] <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res;
        end
        if (do_write) begin
            last_loaded_reg[lsel] <= req.value;
            if (!head_valid_reg[lsel]) begin
                head_value_reg[lsel] <= req.value;
            end
        end
        if (do_read) begin
            refill_list_reg <= win.idx;
        end
        if (state_reg == ST_REFILL) begin
            head_value_reg[refill_list_reg] <= rd_data_reg;
        end
    end

    `KWM_ASSERT_NEXT(a_refill_len, state_reg == ST_REFILL, state_reg == ST_IDLE, "refill too long")
    `KWM_ASSERT_SAME(a_refill_stall, state_reg == ST_REFILL, !s_ready, "accept during refill")
    `KWM_ASSERT_NEXT(a_pop_starts_refill, do_read, state_reg == ST_REFILL, "no refill after pop")
    `KWM_ASSERT_NEXT(a_clear_drops_heads, do_clear, head_valid_reg == '0, "clear left a valid head")
    `KWM_ASSERT_SAME(a_no_win_no_heads, !win.found, head_valid_reg == '0, "head lost by selection")

endmodule
